>>> hdl/edp_pkg.sv
// edp_pkg: shared constants, beat types and register codes of the error diffusion dot placer
// no dependencies; imported by edp_line_store, edp_diffuse and the top level
package edp_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_HEIGHT     = 1024;
   localparam int ERROR_BITS     = 24;

   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
   localparam int W_BITS         = COL_BITS + 1;
   localparam int H_BITS         = ROW_BITS + 1;
   localparam int DIM_BITS       = 11;
   localparam int GAIN_BITS      = 16;
   localparam int VALUE_BITS     = 16;
   localparam int GAIN_FRAC      = 12;
   localparam int PROD_BITS      = VALUE_BITS + GAIN_BITS;
   localparam int SCALED_BITS    = PROD_BITS - GAIN_FRAC;
   localparam int SUM_BITS       = ERROR_BITS + 4;
   localparam int COUNT_BITS     = 21;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam int HALF_Q16       = 32768;
   localparam int ONE_Q16        = 65536;

   localparam logic [GAIN_BITS-1:0]  GAIN_RESET   = GAIN_BITS'(4096);
   localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = DIM_BITS'(1024);
   localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = DIM_BITS'(1024);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GAIN         = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] pixel_value;
      logic                  pixel_valid;
   } req_type;

   typedef struct packed {
      logic                  dot;
      logic [COUNT_BITS-1:0] dot_count;
      logic                  frame_end;
   } rsp_type;

   typedef struct packed {
      logic                         valid;
      logic signed [ERROR_BITS-1:0] err;
   } line_entry_type;

   typedef struct packed {
      logic [SCALED_BITS-1:0] scaled;
      logic                   pixel_valid;
      logic                   row_gt0;
      logic                   col_gt0;
      logic                   col_ge2;
      logic                   right_in;
      logic                   frame_end;
      logic [COL_BITS-1:0]    col;
   } stage_type;

   typedef struct packed {
      line_entry_type               above_left;
      line_entry_type               above;
      line_entry_type               above_right;
      logic signed [ERROR_BITS-1:0] left_err;
      logic                         left_valid;
      logic                         left2_valid;
   } nbr_type;

   typedef struct packed {
      logic                         dot;
      logic signed [ERROR_BITS-1:0] err;
   } diffuse_out_type;

endpackage

>>> hdl/error_diffusion_dot_placer_unit.sv
// error_diffusion_dot_placer_unit: top level, pixel stream in, dot beats out
// depends on edp_pkg, edp_line_store and edp_diffuse
//
// Floyd-Steinberg dot placer for a raster pixel stream. One pixel beat is taken per clock
// unless the output stalls; one result beat comes out per pixel, via the execute stage and
// output register. The sustained rate is one pixel per cycle, set by the single read port of
// the line store, which is read one column ahead of the pixel being diffused. After reset, or
// after a frame_width change that moves the current column, the first pixel waits while the
// column at hand is fetched. The line store needs no clearing after reset. The user writes
// registers through csr_write/csr_index/csr_wdata only while the block is idle (unenforced).
module error_diffusion_dot_placer_unit
   import edp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [GAIN_BITS-1:0]  gain_ff;
   logic [DIM_BITS-1:0]   width_ff;
   logic [DIM_BITS-1:0]   height_ff;

   logic [W_BITS-1:0]     w_eff;
   logic [H_BITS-1:0]     h_eff;
   logic [COL_BITS-1:0]   w_last;
   logic [ROW_BITS-1:0]   h_last;
   logic [COL_BITS-1:0]   cur_col;
   logic [ROW_BITS-1:0]   cur_row;
   logic                  col_is_last;
   logic                  frame_end_now;
   logic [COL_BITS-1:0]   ahead_addr;

   logic [COL_BITS-1:0]   col_ff;
   logic [COL_BITS-1:0]   col_in;
   logic [ROW_BITS-1:0]   row_ff;
   logic [ROW_BITS-1:0]   row_in;
   logic [COL_BITS-1:0]   pre_addr_ff;
   logic [COL_BITS-1:0]   pre_addr_in;
   logic                  pre_ok_ff;
   logic                  pre_ok_in;
   logic                  fix_ff;
   logic                  fix_in;

   logic                  need_fix;
   logic                  fix_start;
   logic                  accept;
   logic                  out_free;
   logic                  s1_go;

   logic [PROD_BITS-1:0]  product;
   stage_type             stage_in;
   stage_type             stage_ff;
   logic                  s1_valid_ff;
   logic                  s1_valid_in;

   line_entry_type        above_ff;
   line_entry_type        above_left_ff;
   logic signed [ERROR_BITS-1:0] left_err_ff;
   logic                  recent0_ff;
   logic                  recent1_ff;

   logic                  rd_en;
   logic [COL_BITS-1:0]   rd_addr;
   line_entry_type        rd_data;
   line_entry_type        wr_data;
   nbr_type               nbr;
   diffuse_out_type       diff;
   logic                  self_ahead;

   logic [COUNT_BITS-1:0] total_ff;
   logic [COUNT_BITS-1:0] total_in;
   logic [COUNT_BITS-1:0] count_next;
   rsp_type               rsp_data_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_GAIN:         gain_ff   <= csr_wdata[GAIN_BITS-1:0];
            CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[DIM_BITS-1:0];
            CSR_FRAME_HEIGHT: height_ff <= csr_wdata[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   // grid position of the pixel at the input
   always_comb begin
      if (width_ff == '0) begin
         w_eff = W_BITS'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = W_BITS'(MAX_WIDTH);
      end else begin
         w_eff = W_BITS'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = H_BITS'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_eff = H_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = H_BITS'(height_ff);
      end
      w_last        = COL_BITS'(w_eff - W_BITS'(1));
      h_last        = ROW_BITS'(h_eff - H_BITS'(1));
      cur_col       = (col_ff > w_last) ? w_last : col_ff;
      cur_row       = (row_ff > h_last) ? h_last : row_ff;
      col_is_last   = (cur_col == w_last);
      frame_end_now = col_is_last && (cur_row == h_last);
      ahead_addr    = col_is_last ? '0 : cur_col + COL_BITS'(1);
   end

   // handshake and fetch control
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      s1_go     = s1_valid_ff && out_free;
      need_fix  = !pre_ok_ff || (pre_addr_ff != cur_col);
      req_ready = (!s1_valid_ff || out_free) && !need_fix && !fix_ff;
      accept    = req_valid && req_ready;
      fix_start = !s1_valid_ff && need_fix && !fix_ff;
      rd_en     = accept || fix_start;
      rd_addr   = fix_start ? cur_col : ahead_addr;
   end

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      pre_addr_in = pre_addr_ff;
      pre_ok_in   = pre_ok_ff;
      fix_in      = fix_start;
      if (accept) begin
         col_in      = col_is_last ? '0 : cur_col + COL_BITS'(1);
         row_in      = frame_end_now ? '0 :
                       (col_is_last ? cur_row + ROW_BITS'(1) : cur_row);
         pre_addr_in = ahead_addr;
      end else if (fix_ff) begin
         pre_addr_in = cur_col;
         pre_ok_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         pre_addr_ff <= '0;
         pre_ok_ff   <= 1'b0;
         fix_ff      <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         pre_addr_ff <= pre_addr_in;
         pre_ok_ff   <= pre_ok_in;
         fix_ff      <= fix_in;
      end
   end

   // accept stage: gain scaling and position flags
   always_comb begin
      product              = PROD_BITS'(req_data.pixel_value) * PROD_BITS'(gain_ff);
      stage_in.scaled      = product[PROD_BITS-1:GAIN_FRAC];
      stage_in.pixel_valid = req_data.pixel_valid;
      stage_in.row_gt0     = (cur_row != '0);
      stage_in.col_gt0     = (cur_col != '0);
      stage_in.col_ge2     = (cur_col >= COL_BITS'(2));
      stage_in.right_in    = !col_is_last;
      stage_in.frame_end   = frame_end_now;
      stage_in.col         = cur_col;
      s1_valid_in          = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   edp_line_store u_line_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr_en   (s1_go),
      .wr_addr (stage_ff.col),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   always_comb begin
      nbr.above_left  = above_left_ff;
      nbr.above       = above_ff;
      nbr.above_right = rd_data;
      nbr.left_err    = left_err_ff;
      nbr.left_valid  = recent0_ff;
      nbr.left2_valid = recent1_ff;
      wr_data.valid   = stage_ff.pixel_valid;
      wr_data.err     = diff.err;
      self_ahead      = !stage_ff.right_in && (stage_ff.col == '0);
   end

   edp_diffuse u_diffuse (
      .stage  (stage_ff),
      .nbr    (nbr),
      .result (diff)
   );

   // neighbor window slides one column per executed pixel
   // a one-column row takes its own result as the next pixel's above
   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff      <= '0;
         above_left_ff <= '0;
         left_err_ff   <= '0;
         recent0_ff    <= 1'b0;
         recent1_ff    <= 1'b0;
      end else begin
         if (s1_go && self_ahead) begin
            above_ff <= wr_data;
         end else if (s1_go || fix_ff) begin
            above_ff <= rd_data;
         end
         if (s1_go) begin
            above_left_ff <= above_ff;
            left_err_ff   <= diff.err;
            recent0_ff    <= stage_ff.pixel_valid;
            recent1_ff    <= recent0_ff;
         end
      end
   end

   // dot count and output register
   always_comb begin
      count_next   = (diff.dot && (total_ff != COUNT_MAX)) ?
                     total_ff + COUNT_BITS'(1) : total_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (s1_go) begin
         total_in     = stage_ff.frame_end ? '0 : count_next;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_data_ff.dot       <= diff.dot;
         rsp_data_ff.dot_count <= count_next;
         rsp_data_ff.frame_end <= stage_ff.frame_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted beat did not reach the execute stage");

   a_stage_to_output: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> rsp_valid_ff)
      else $error("executed pixel did not produce a result beat");

   a_fetch_alone: assert property (@(posedge clock) disable iff (reset)
      fix_ff |-> (!s1_valid_ff && !(req_valid && req_ready)))
      else $error("column fetch overlapped a pixel in flight");

   a_fetch_settles: assert property (@(posedge clock) disable iff (reset)
      fix_ff |=> (pre_ok_ff && (pre_addr_ff == $past(cur_col))))
      else $error("column fetch left the read-ahead address wrong");

endmodule

>>> hdl/edp_line_store.sv
// edp_line_store: one-row store of diffused error and valid bit per column
// synchronous memory, one read and one write port, registered read with write forwarding
// depends on edp_pkg
module edp_line_store
   import edp_pkg::*;
(
   input  logic                clock,
   input  logic                rd_en,
   input  logic [COL_BITS-1:0] rd_addr,
   input  logic                wr_en,
   input  logic [COL_BITS-1:0] wr_addr,
   input  line_entry_type      wr_data,
   output line_entry_type      rd_data
);

   line_entry_type store_mem [MAX_WIDTH];
   line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // same-cycle write to the read address is passed straight through
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= store_mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/edp_diffuse.sv
// edp_diffuse: adds the error shares of the four causal neighbors, thresholds and forms the residual
// combinational, fed by the execute stage register of the top level; depends on edp_pkg
module edp_diffuse
   import edp_pkg::*;
(
   input  stage_type       stage,
   input  nbr_type         nbr,
   output diffuse_out_type result
);

   localparam logic [3:0] K_LEFT  = 4'd7;
   localparam logic [3:0] K_ABOVE = 4'd5;
   localparam logic [3:0] K_RIGHT = 4'd3;

   localparam logic signed [SUM_BITS-1:0] ERR_HI =
      SUM_BITS'((longint'(1) <<< (ERROR_BITS - 1)) - 1);
   localparam logic signed [SUM_BITS-1:0] ERR_LO = ~ERR_HI;
   localparam logic signed [SUM_BITS-1:0] HALF   = SUM_BITS'(HALF_Q16);
   localparam logic signed [SUM_BITS-1:0] ONE    = SUM_BITS'(ONE_Q16);

   // floor(k * e / 16)
   function automatic logic signed [SUM_BITS-1:0] share_of(
      input logic signed [ERROR_BITS-1:0] e,
      input logic [3:0]                   k
   );
      logic signed [SUM_BITS-1:0] n;
      n = SUM_BITS'(e) * $signed({1'b0, k});
      return n >>> 4;
   endfunction

   function automatic logic signed [SUM_BITS-1:0] sat_sum(
      input logic signed [SUM_BITS-1:0] v
   );
      logic signed [SUM_BITS-1:0] s;
      if (v > ERR_HI) begin
         s = ERR_HI;
      end else if (v < ERR_LO) begin
         s = ERR_LO;
      end else begin
         s = v;
      end
      return s;
   endfunction

   logic                       prev_m1;
   logic                       prev_0;
   logic                       prev_p1;
   logic                       left_ok;
   logic                       left2_ok;
   logic signed [SUM_BITS-1:0] remainder;
   logic signed [SUM_BITS-1:0] acc_raw;
   logic signed [SUM_BITS-1:0] acc_sat;
   logic signed [SUM_BITS-1:0] resid;
   logic                       dot_on;

   always_comb begin
      prev_m1  = stage.row_gt0 && stage.col_gt0 && nbr.above_left.valid;
      prev_0   = stage.row_gt0 && nbr.above.valid;
      prev_p1  = stage.row_gt0 && stage.right_in && nbr.above_right.valid;
      left_ok  = stage.col_gt0 && nbr.left_valid;
      left2_ok = stage.col_ge2 && nbr.left2_valid;

      // below-right share: whatever the passed shares left over
      remainder = SUM_BITS'(nbr.above_left.err);
      if (prev_0) begin
         remainder = remainder - share_of(nbr.above_left.err, K_LEFT);
      end
      if (left2_ok) begin
         remainder = remainder - share_of(nbr.above_left.err, K_RIGHT);
      end
      if (left_ok) begin
         remainder = remainder - share_of(nbr.above_left.err, K_ABOVE);
      end

      acc_raw = $signed(SUM_BITS'(stage.scaled));
      if (left_ok) begin
         acc_raw = acc_raw + share_of(nbr.left_err, K_LEFT);
      end
      if (prev_0) begin
         acc_raw = acc_raw + share_of(nbr.above.err, K_ABOVE);
      end
      if (prev_p1) begin
         acc_raw = acc_raw + share_of(nbr.above_right.err, K_RIGHT);
      end
      if (prev_m1) begin
         acc_raw = acc_raw + remainder;
      end

      acc_sat = sat_sum(acc_raw);
      dot_on  = stage.pixel_valid && (acc_sat >= HALF);
      resid   = sat_sum(dot_on ? (acc_sat - ONE) : acc_sat);

      result.dot = dot_on;
      result.err = stage.pixel_valid ? resid[ERROR_BITS-1:0] : '0;
   end

endmodule
